@@ rtl/obb_ovl_pkg.sv @@
// ----------------------------------------------------------------------------
// OBB versus AABB overlap package
// Register map codes and fixed widths shared by the overlap test modules.
// ----------------------------------------------------------------------------
package obb_ovl_pkg;

  localparam int REG_W      = 63;
  localparam int IN_W       = 21;
  localparam int TAG_W      = 16;
  localparam int CFG_DW     = 64;
  localparam int CFG_AW     = 6;
  localparam int SETTLE_CYC = 3;

  typedef enum logic [2:0] {
    REG_CENTER   = 3'd0,
    REG_ROW_X    = 3'd1,
    REG_ROW_Y    = 3'd2,
    REG_ROW_Z    = 3'd3,
    REG_HALF_EXT = 3'd4
  } reg_idx_t;

endpackage

@@ rtl/obb_ovl_setup.sv @@
// ----------------------------------------------------------------------------
// OBB setup sequencer
// Derives row lengths, unit axes, their absolute values plus one LSB, and the
// doubled world half extents from the box registers; roots and quotients are formed one bit per cycle.
// ----------------------------------------------------------------------------
module obb_ovl_setup #(
  parameter int COORD_BITS = 21,
  parameter int FRAC_BITS  = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [obb_ovl_pkg::REG_W-1:0]         row_cfg [3],
  input  logic [obb_ovl_pkg::REG_W-1:0]         ext_cfg,
  output logic                                  busy,
  output logic signed [FRAC_BITS+1:0]           u_o     [3][3],
  output logic [FRAC_BITS+1:0]                  a_o     [3][3],
  output logic signed [2*COORD_BITS+1:0]        b2_o    [3]
);
  import obb_ovl_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int SQW = 2 * C;
  localparam int NW  = C + F;
  localparam int CW  = $clog2(NW + 1);
  localparam int UW  = F + 2;
  localparam int BW  = 2 * C + 2;

  typedef enum logic [2:0] {
    ST_SQ, ST_ROOT, ST_SCALE, ST_LOAD, ST_DIV, ST_SETTLE, ST_IDLE
  } state_t;

  state_t          state_r;
  logic [1:0]      row_r;
  logic [1:0]      k_r;
  logic [CW-1:0]   cnt_r;
  logic [SQW-1:0]  acc_r;
  logic [SQW:0]    res_r;
  logic [SQW-1:0]  bit_r;
  logic [C-1:0]    s_r;
  logic [NW-1:0]   num_r;
  logic [C-1:0]    rem_r;
  logic [NW-1:0]   quo_r;
  logic            neg_r;

  logic signed [C-1:0]   r_sel;
  logic [C-1:0]          r_mag;
  logic signed [SQW-1:0] sq_term;
  logic [SQW-1:0]        acc_sum;
  logic [SQW:0]          trial_sum;
  logic [SQW-1:0]        root_n_nxt;
  logic [SQW:0]          root_res_nxt;
  logic [C:0]            dtrial;
  logic                  dge;
  logic [C-1:0]          div_rem_nxt;
  logic [NW-1:0]         div_quo_nxt;
  logic [F:0]            q_val;
  logic signed [UW-1:0]  u_val;
  logic [UW-1:0]         a_val;
  logic signed [C-1:0]   e_sel;
  logic signed [2*C:0]   es_prod;
  logic signed [BW-1:0]  b2_val;

  always_comb begin
    r_sel   = row_cfg[row_r][k_r*C +: C];
    r_mag   = r_sel[C-1] ? (~r_sel + 1'b1) : r_sel;
    sq_term = r_sel * r_sel;
    acc_sum = acc_r + sq_term;

    trial_sum = res_r + {1'b0, bit_r};
    if ({1'b0, acc_r} >= trial_sum) begin
      root_n_nxt   = acc_r - trial_sum[SQW-1:0];
      root_res_nxt = (res_r >> 1) + {1'b0, bit_r};
    end else begin
      root_n_nxt   = acc_r;
      root_res_nxt = res_r >> 1;
    end

    dtrial      = {rem_r, num_r[NW-1]};
    dge         = dtrial >= {1'b0, s_r};
    div_rem_nxt = dge ? C'(dtrial - {1'b0, s_r}) : dtrial[C-1:0];
    div_quo_nxt = {quo_r[NW-2:0], dge};
    q_val       = div_quo_nxt[F:0];
    if (s_r == '0) begin
      u_val = '0;
      a_val = UW'(1);
    end else begin
      u_val = neg_r ? -$signed(UW'(q_val)) : $signed(UW'(q_val));
      a_val = UW'(q_val) + UW'(1);
    end

    e_sel   = ext_cfg[row_r*C +: C];
    es_prod = e_sel * $signed({1'b0, s_r});
    b2_val  = $signed({es_prod, 1'b0});
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      state_r <= ST_SQ;
      row_r   <= '0;
      k_r     <= '0;
      cnt_r   <= '0;
      acc_r   <= '0;
    end else begin
      unique case (state_r)
        ST_SQ: begin
          acc_r <= acc_sum;
          if (k_r == 2'd2) begin
            k_r     <= '0;
            res_r   <= '0;
            bit_r   <= SQW'(1) << (SQW - 2);
            cnt_r   <= '0;
            state_r <= ST_ROOT;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        ST_ROOT: begin
          acc_r <= root_n_nxt;
          res_r <= root_res_nxt;
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(C - 1)) begin
            s_r     <= root_res_nxt[C-1:0];
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          b2_o[row_r] <= b2_val;
          state_r     <= ST_LOAD;
        end
        ST_LOAD: begin
          num_r   <= {r_mag, F'(0)};
          neg_r   <= r_sel[C-1];
          rem_r   <= '0;
          quo_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          num_r <= num_r << 1;
          rem_r <= div_rem_nxt;
          quo_r <= div_quo_nxt;
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(NW - 1)) begin
            u_o[k_r][row_r] <= u_val;
            a_o[k_r][row_r] <= a_val;
            cnt_r           <= '0;
            if (k_r == 2'd2) begin
              k_r <= '0;
              if (row_r == 2'd2) begin
                state_r <= ST_SETTLE;
              end else begin
                row_r   <= row_r + 2'd1;
                acc_r   <= '0;
                state_r <= ST_SQ;
              end
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= ST_LOAD;
            end
          end
        end
        ST_SETTLE: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(SETTLE_CYC - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          cnt_r <= '0;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/obb_aabb_overlap_test.sv @@
// ----------------------------------------------------------------------------
// OBB versus AABB overlap test
// An accepted input beat passes the stage 1, 2 and 3 registers and the output register.
// Throughput: one beat per cycle through a four-stage pipeline unless out_stall or busy holds it.
// After reset and after every register write the setup sequencer derives the
// axes serially; in_stall stays high while it runs. Reset clears the
// configuration registers and the pipeline valid bits.
// ----------------------------------------------------------------------------
module obb_aabb_overlap_test #(
  parameter int COORD_BITS = 21,
  parameter int FRAC_BITS  = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [obb_ovl_pkg::CFG_AW-1:0]    paddr,
  input  logic [obb_ovl_pkg::CFG_DW-1:0]    pwdata,
  output logic [obb_ovl_pkg::CFG_DW-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [obb_ovl_pkg::IN_W-1:0]      in_aabb_min_x,
  input  logic [obb_ovl_pkg::IN_W-1:0]      in_aabb_min_y,
  input  logic [obb_ovl_pkg::IN_W-1:0]      in_aabb_min_z,
  input  logic [obb_ovl_pkg::IN_W-1:0]      in_aabb_max_x,
  input  logic [obb_ovl_pkg::IN_W-1:0]      in_aabb_max_y,
  input  logic [obb_ovl_pkg::IN_W-1:0]      in_aabb_max_z,
  input  logic [obb_ovl_pkg::TAG_W-1:0]     in_item_tag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_overlap_hit,
  output logic [obb_ovl_pkg::TAG_W-1:0]     out_result_tag
);
  import obb_ovl_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int TW   = C + 3;
  localparam int UW   = F + 2;
  localparam int AW   = F + 2;
  localparam int BW   = 2 * C + 2;
  localparam int PW   = BW + AW + 1;
  localparam int WAW  = PW + 2;
  localparam int RBW  = PW + 1;
  localparam int PRW  = TW + UW;
  localparam int ARW  = TW + AW + 1;
  localparam int DW   = PRW + 2;
  localparam int XW   = 2 * C + 2 * F + 8;

  // Configuration registers.
  logic [REG_W-1:0] center_r;
  logic [REG_W-1:0] rowcfg_r [3];
  logic [REG_W-1:0] ext_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[5:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r    <= '0;
      rowcfg_r[0] <= '0;
      rowcfg_r[1] <= '0;
      rowcfg_r[2] <= '0;
      ext_r       <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CENTER:   center_r    <= pwdata[REG_W-1:0];
        REG_ROW_X:    rowcfg_r[0] <= pwdata[REG_W-1:0];
        REG_ROW_Y:    rowcfg_r[1] <= pwdata[REG_W-1:0];
        REG_ROW_Z:    rowcfg_r[2] <= pwdata[REG_W-1:0];
        REG_HALF_EXT: ext_r       <= pwdata[REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CENTER:   prdata = {1'b0, center_r};
      REG_ROW_X:    prdata = {1'b0, rowcfg_r[0]};
      REG_ROW_Y:    prdata = {1'b0, rowcfg_r[1]};
      REG_ROW_Z:    prdata = {1'b0, rowcfg_r[2]};
      REG_HALF_EXT: prdata = {1'b0, ext_r};
      default:      prdata = '0;
    endcase
  end

  // Derived box constants.
  logic                  busy;
  logic signed [UW-1:0]  u_v  [3][3];
  logic [AW-1:0]         a_v  [3][3];
  logic signed [BW-1:0]  b2_v [3];

  obb_ovl_setup #(
    .COORD_BITS (C),
    .FRAC_BITS  (F)
  ) u_setup (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cfg_wr),
    .row_cfg (rowcfg_r),
    .ext_cfg (ext_r),
    .busy    (busy),
    .u_o     (u_v),
    .a_o     (a_v),
    .b2_o    (b2_v)
  );

  logic signed [PW-1:0]  p_r  [3][3][3];
  logic signed [WAW-1:0] wa_r [3];
  logic signed [RBW-1:0] rb_r [3][3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int m = 0; m < 3; m++) begin
        for (int n = 0; n < 3; n++) begin
          p_r[i][m][n] <= b2_v[m] * $signed({1'b0, a_v[i][n]});
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      wa_r[i] <= WAW'(p_r[i][0][0]) + WAW'(p_r[i][1][1]) + WAW'(p_r[i][2][2]);
      rb_r[i][0] <= RBW'(p_r[i][1][2]) + RBW'(p_r[i][2][1]);
      rb_r[i][1] <= RBW'(p_r[i][2][0]) + RBW'(p_r[i][0][2]);
      rb_r[i][2] <= RBW'(p_r[i][0][1]) + RBW'(p_r[i][1][0]);
    end
  end

  // Pipeline flow control.
  logic v_s1_r, v_s2_r, v_s3_r, v_o_r;
  logic en_s1, en_s2, en_s3, en_o;

  assign en_o     = !v_o_r || !out_stall;
  assign en_s3    = !v_s3_r || en_o;
  assign en_s2    = !v_s2_r || en_s3;
  assign en_s1    = !v_s1_r || en_s2;
  assign in_stall = !en_s1 || busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r <= 1'b0;
      v_s2_r <= 1'b0;
      v_s3_r <= 1'b0;
      v_o_r  <= 1'b0;
    end else begin
      if (en_s1) v_s1_r <= in_valid && !busy;
      if (en_s2) v_s2_r <= v_s1_r;
      if (en_s3) v_s3_r <= v_s2_r;
      if (en_o)  v_o_r  <= v_s3_r;
    end
  end

  // Stage 1: doubled center offset and box size.
  logic [IN_W-1:0]       in_min [3];
  logic [IN_W-1:0]       in_max [3];
  logic signed [TW-1:0]  t2_nxt [3];
  logic signed [TW-1:0]  a2_nxt [3];
  logic signed [TW-1:0]  t2_s1_r [3];
  logic signed [TW-1:0]  a2_s1_r [3];
  logic [TAG_W-1:0]      tag_s1_r;

  assign in_min[0] = in_aabb_min_x;
  assign in_min[1] = in_aabb_min_y;
  assign in_min[2] = in_aabb_min_z;
  assign in_max[0] = in_aabb_max_x;
  assign in_max[1] = in_aabb_max_y;
  assign in_max[2] = in_aabb_max_z;

  always_comb begin
    logic signed [C-1:0] mn, mx, cc;
    for (int k = 0; k < 3; k++) begin
      mn = in_min[k][C-1:0];
      mx = in_max[k][C-1:0];
      cc = center_r[k*C +: C];
      t2_nxt[k] = (TW'(cc) <<< 1) - (TW'(mn) + TW'(mx));
      a2_nxt[k] = TW'(mx) - TW'(mn);
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      t2_s1_r  <= t2_nxt;
      a2_s1_r  <= a2_nxt;
      tag_s1_r <= in_item_tag;
    end
  end

  // Stage 2: projections onto the box axes.
  logic signed [PRW-1:0] tr_s2_r [3][3][3];
  logic signed [ARW-1:0] ar_s2_r [3][3][3];
  logic [TW-1:0]         t2m_s2_r [3];
  logic signed [TW-1:0]  a2_s2_r  [3];
  logic [TAG_W-1:0]      tag_s2_r;

  always_ff @(posedge clk) begin
    if (en_s2) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          for (int j = 0; j < 3; j++) begin
            tr_s2_r[a][b][j] <= t2_s1_r[a] * u_v[b][j];
            ar_s2_r[a][b][j] <= a2_s1_r[a] * $signed({1'b0, a_v[b][j]});
          end
        end
        t2m_s2_r[a] <= t2_s1_r[a][TW-1] ? TW'(-t2_s1_r[a]) : TW'(t2_s1_r[a]);
      end
      a2_s2_r  <= a2_s1_r;
      tag_s2_r <= tag_s1_r;
    end
  end

  // Stage 3: sums and magnitudes.
  logic [DW-1:0]           dm_s3_r  [3];
  logic signed [ARW+1:0]   ra_s3_r  [3];
  logic [PRW:0]            cm_s3_r  [3][3];
  logic signed [ARW:0]     rac_s3_r [3][3];
  logic [TW-1:0]           t2m_s3_r [3];
  logic signed [TW-1:0]    a2_s3_r  [3];
  logic [TAG_W-1:0]        tag_s3_r;
  logic signed [DW-1:0]    dot_c    [3];
  logic signed [PRW:0]     crs_c    [3][3];

  always_comb begin
    int i1, i2;
    for (int j = 0; j < 3; j++) begin
      dot_c[j] = DW'(tr_s2_r[0][0][j]) + DW'(tr_s2_r[1][1][j]) + DW'(tr_s2_r[2][2][j]);
    end
    for (int i = 0; i < 3; i++) begin
      i1 = (i == 2) ? 0 : i + 1;
      i2 = (i == 0) ? 2 : i - 1;
      for (int j = 0; j < 3; j++) begin
        crs_c[i][j] = (PRW+1)'(tr_s2_r[i2][i1][j]) - (PRW+1)'(tr_s2_r[i1][i2][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    int i1, i2;
    if (en_s3) begin
      for (int j = 0; j < 3; j++) begin
        dm_s3_r[j] <= dot_c[j][DW-1] ? DW'(-dot_c[j]) : DW'(dot_c[j]);
        ra_s3_r[j] <= (ARW+2)'(ar_s2_r[0][0][j]) + (ARW+2)'(ar_s2_r[1][1][j])
                    + (ARW+2)'(ar_s2_r[2][2][j]);
      end
      for (int i = 0; i < 3; i++) begin
        i1 = (i == 2) ? 0 : i + 1;
        i2 = (i == 0) ? 2 : i - 1;
        for (int j = 0; j < 3; j++) begin
          cm_s3_r[i][j]  <= crs_c[i][j][PRW] ? (PRW+1)'(-crs_c[i][j])
                                             : (PRW+1)'(crs_c[i][j]);
          rac_s3_r[i][j] <= (ARW+1)'(ar_s2_r[i1][i2][j]) + (ARW+1)'(ar_s2_r[i2][i1][j]);
        end
      end
      t2m_s3_r <= t2m_s2_r;
      a2_s3_r  <= a2_s2_r;
      tag_s3_r <= tag_s2_r;
    end
  end

  // Stage 4: the fifteen comparisons.
  logic hit_nxt;

  always_comb begin
    logic signed [XW-1:0] lhs, rhs;
    hit_nxt = 1'b1;
    for (int i = 0; i < 3; i++) begin
      lhs = $signed(XW'(t2m_s3_r[i])) <<< (2 * F);
      rhs = (XW'(a2_s3_r[i]) <<< (2 * F)) + XW'(wa_r[i]);
      if (lhs > rhs) hit_nxt = 1'b0;
    end
    for (int j = 0; j < 3; j++) begin
      lhs = $signed(XW'(dm_s3_r[j]));
      rhs = XW'(b2_v[j]) + XW'(ra_s3_r[j]);
      if (lhs > rhs) hit_nxt = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        lhs = $signed(XW'(cm_s3_r[i][j])) <<< F;
        rhs = (XW'(rac_s3_r[i][j]) <<< F) + XW'(rb_r[i][j]);
        if (lhs > rhs) hit_nxt = 1'b0;
      end
    end
  end

  logic             hit_r;
  logic [TAG_W-1:0] tag_o_r;

  always_ff @(posedge clk) begin
    if (en_o) begin
      hit_r   <= hit_nxt;
      tag_o_r <= tag_s3_r;
    end
  end

  assign out_valid       = v_o_r;
  assign out_overlap_hit = hit_r;
  assign out_result_tag  = tag_o_r;

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall)
    else $error("input accepted while box constants are recomputed");

  a_write_starts_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> busy)
    else $error("register write did not start the setup sequencer");

  a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_s2_r && !en_s2) |=> (v_s2_r && $stable(tag_s2_r)))
    else $error("stalled beat in stage two was lost or changed");

endmodule
